// File: rtl/core/eet_pkg.sv
// eet_pkg: shared types and constants for the extended Euclid table unit.
// No dependencies.
package eet_pkg;

    localparam int ROW_W  = 6;
    localparam int OUT_W  = 31;
    localparam int COEF_W = 32;

    // result row handed from the sequencer to the output register
    typedef struct packed {
        logic [ROW_W-1:0]  row_number;
        logic [OUT_W-1:0]  remainder;
        logic [OUT_W-1:0]  quotient;
        logic [COEF_W-1:0] coef_s;
        logic [COEF_W-1:0] coef_t;
        logic              last_row;
    } eet_row_t;

endpackage

// File: rtl/core/eet_divider.sv
// eet_divider: restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameter.
module eet_divider #(
    parameter int W = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// File: rtl/core/eet_mulsub.sv
// eet_mulsub: older - newer*q mod 2^32, shift-and-subtract one multiplier bit per cycle.
// Uses eet_pkg for the coefficient width.
module eet_mulsub #(
    parameter int QW = 31
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [eet_pkg::COEF_W-1:0] older,
    input  logic [eet_pkg::COEF_W-1:0] newer,
    input  logic [QW-1:0]             q,
    output logic                      done,
    output logic [eet_pkg::COEF_W-1:0] result
);
    import eet_pkg::*;
    localparam int CW = $clog2(QW + 1);

    logic [COEF_W-1:0] acc_reg, acc_next;
    logic [COEF_W-1:0] mcd_reg, mcd_next;
    logic [QW-1:0]     mpl_reg, mpl_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // subtract the shifted multiplicand per set quotient bit
    always_comb
    begin
        acc_next  = acc_reg;
        mcd_next  = mcd_reg;
        mpl_next  = mpl_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = older;
            mcd_next  = newer;
            mpl_next  = q;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mpl_reg[0])
                acc_next = acc_reg - mcd_reg;
            mcd_next = {mcd_reg[COEF_W-2:0], 1'b0};
            mpl_next = mpl_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpl_reg <= mpl_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;
endmodule

// File: rtl/core/extended_euclid_table_unit.sv
// extended_euclid_table_unit: emits the extended Euclid table row by row (eet_pkg, eet_divider, eet_mulsub).
// Rows 0 and 1 are loaded out from the ROW0 and ROW1 states once the request is taken and the output is free.
// Each division row runs kick, bit-serial divide, handoff, kick, the two bit-serial multiply-subtracts
// side by side, emit; output stalls hold the emit step. One pair at a time, up to 48 rows (MAX_ROWS);
// the next request is taken once the last row is loaded out. rst_n is asynchronous, active low, and
// clears the sequencer and output register.
module extended_euclid_table_unit #(
    parameter int OPERAND_WIDTH = 31,
    parameter int MAX_ROWS      = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // first_value[30:0], second_value[61:31], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [135:0] m_tdata,  // row_number, remainder, quotient, coef_s, coef_t, zero pad
    output logic        m_tlast    // last_row
);
    import eet_pkg::*;
    localparam int W = OPERAND_WIDTH;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROW0 = 3'd1;
    localparam logic [2:0] ST_ROW1 = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]        st_reg, st_next;
    logic [W-1:0]      dvd_reg, dvs_reg, q_reg;
    logic [COEF_W-1:0] os_reg, ns_reg, ot_reg, nt_reg;
    logic [ROW_W-1:0]  rc_reg;
    eet_row_t          out_reg;
    logic              ov_reg;
    logic              div_start, div_done, mul_start, s_done, t_done;
    logic [W-1:0]      div_q, div_r;
    logic [COEF_W-1:0] s_res, t_res;
    logic              out_free, r_last;
    logic [W-1:0]      in_a, in_b;
    logic              go_div_reg;
    logic              go_mul_reg;
    logic              row1_last;
    logic              out_load;

    assign in_a = W'(s_tdata[30:0]);
    assign in_b = W'(s_tdata[61:31]);

    eet_divider #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd_reg),
        .divisor(dvs_reg), .done(div_done), .quotient(div_q), .remainder(div_r)
    );
    eet_mulsub #(.QW(W)) u_ms (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .older(os_reg), .newer(ns_reg),
        .q(q_reg), .done(s_done), .result(s_res)
    );
    eet_mulsub #(.QW(W)) u_mt (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .older(ot_reg), .newer(nt_reg),
        .q(q_reg), .done(t_done), .result(t_res)
    );

    assign out_free  = !ov_reg || m_tready;
    assign s_tready  = (st_reg == ST_IDLE);
    assign div_start = go_div_reg;
    assign mul_start = go_mul_reg;
    assign row1_last = (dvs_reg <= W'(1));
    assign r_last    = (div_r <= W'(1)) ||
                       ({1'b0, rc_reg} + 7'd1 >= 7'(MAX_ROWS));
    assign out_load  = out_free &&
                       ((st_reg == ST_ROW0) || (st_reg == ST_ROW1) || (st_reg == ST_EMIT));

    // output valid and unit kicks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg     <= 1'b0;
            go_div_reg <= 1'b0;
            go_mul_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
            go_div_reg <= out_load &&
                          (((st_reg == ST_ROW1) && !row1_last) ||
                           ((st_reg == ST_EMIT) && !r_last));
            go_mul_reg <= (st_reg == ST_DIV) && div_done;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            dvd_reg <= '0;
            dvs_reg <= '0;
            q_reg   <= '0;
            os_reg  <= COEF_W'(1);
            ns_reg  <= '0;
            ot_reg  <= '0;
            nt_reg  <= COEF_W'(1);
            rc_reg  <= '0;
            out_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        dvd_reg <= in_a;
                        dvs_reg <= in_b;
                        os_reg  <= COEF_W'(1);
                        ns_reg  <= '0;
                        ot_reg  <= '0;
                        nt_reg  <= COEF_W'(1);
                        rc_reg  <= '0;
                        st_reg  <= ST_ROW0;
                    end
                end
                ST_ROW0:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{rc_reg, OUT_W'(dvd_reg), '0, COEF_W'(1), '0, 1'b0};
                        rc_reg  <= rc_reg + 1'b1;
                        st_reg  <= ST_ROW1;
                    end
                end
                ST_ROW1:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{rc_reg, OUT_W'(dvs_reg), '0, '0, COEF_W'(1), row1_last};
                        rc_reg  <= rc_reg + 1'b1;
                        if (row1_last)
                            st_reg <= ST_IDLE;
                        else
                            st_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        q_reg  <= div_q;
                        st_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (s_done && t_done)
                        st_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{rc_reg, OUT_W'(div_r), OUT_W'(q_reg), s_res, t_res,
                                     r_last};
                        rc_reg  <= rc_reg + 1'b1;
                        os_reg  <= ns_reg;
                        ns_reg  <= s_res;
                        ot_reg  <= nt_reg;
                        nt_reg  <= t_res;
                        dvd_reg <= dvs_reg;
                        dvs_reg <= div_r;
                        if (r_last)
                            st_reg <= ST_IDLE;
                        else
                            st_reg <= ST_DIV;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0000, out_reg.coef_t, out_reg.coef_s, out_reg.quotient,
                       out_reg.remainder, out_reg.row_number};
    assign m_tlast  = out_reg.last_row;

`ifndef NO_ASSERTIONS
    eet_div_kick: assert property (@(posedge clk) disable iff (!rst_n)
        go_div_reg |-> st_reg == ST_DIV)
        else $error("divide kicked outside divide state");
    eet_ms_sync: assert property (@(posedge clk) disable iff (!rst_n)
        s_done == t_done)
        else $error("coefficient units out of step");
    eet_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ST_IDLE |-> !s_tready)
        else $error("request taken while busy");
`endif
endmodule
